### sv/mzcm_pkg.sv
`default_nettype none
// ============================================================================
// mzcm_pkg
// Shared types and constants of the mains zero-cross monitor.
// ============================================================================
package mzcm_pkg;

  localparam int CHECK_PERIOD_DEF  = 100;
  localparam int COUNTER_WIDTH_DEF = 32;

  localparam int TICK_W            = 7;
  localparam logic [TICK_W-1:0] TICK_START = 7'd40;

  localparam logic [1:0] WATCHDOG_LIMIT = 2'd2;

  // The frequency numerator is divided bit-serially, one quotient bit a cycle.
  localparam int                 FREQ_NUM_W = 23;
  localparam logic [FREQ_NUM_W-1:0] FREQ_NUM = 23'd5000000;
  localparam int                 DIV_STEPS  = FREQ_NUM_W;
  localparam int                 DIV_CNT_W  = $clog2(DIV_STEPS);

  // Rounding offset and a reciprocal constant for the final divide by ten.
  // (x * 13421773) >> 27 equals x / 10 for every x below 2^26.
  localparam logic [FREQ_NUM_W:0] FREQ_ROUND = 24'd5;
  localparam logic [FREQ_NUM_W:0] RECIP_TEN  = 24'd13421773;
  localparam int                  RECIP_SHIFT = 27;
  localparam int                  FREQ_W      = 19;
  localparam int                  GAP_PORT_W  = 32;

  typedef enum logic [1:0] {
    ST_OFF    = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_SET     = 2'd2
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // apply the accepted transaction to the state
    logic mul_load;  // load the rounded frequency from the quotient
    logic out_load;  // copy the state into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // the offered transaction recomputes the frequency
    logic div_busy;  // the divider is still iterating
    logic out_free;  // the output register can take a result this cycle
  } dp_sts_t;

endpackage : mzcm_pkg
`default_nettype wire

### sv/mzcm_div.sv
`default_nettype none
// ============================================================================
// mzcm_div
// Restoring divider: the fixed frequency numerator over the pulse gap.
// ============================================================================
module mzcm_div
  import mzcm_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [COUNTER_WIDTH-1:0] divisor,
  output logic                          busy,
  output logic [FREQ_NUM_W-1:0]         quotient
);

  logic                     busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [COUNTER_WIDTH-1:0] rem_r, rem_nxt;
  logic [FREQ_NUM_W-1:0]    quot_r, quot_nxt;
  logic [COUNTER_WIDTH:0]   rem_sh;
  logic [COUNTER_WIDTH:0]   rem_sub;
  logic                     ge;

  // The quotient register starts out holding the numerator; its bits shift
  // out at the top while quotient bits shift in at the bottom.
  always_comb begin
    rem_sh   = {rem_r, quot_r[FREQ_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    ge       = (rem_sh >= {1'b0, divisor});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quot_nxt = FREQ_NUM;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[COUNTER_WIDTH-1:0] : rem_sh[COUNTER_WIDTH-1:0];
      quot_nxt = {quot_r[FREQ_NUM_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule : mzcm_div
`default_nettype wire

### sv/mzcm_dp.sv
`default_nettype none
// ============================================================================
// mzcm_dp
// Monitor state, event update logic, frequency rounding and output register.
// ============================================================================
module mzcm_dp
  import mzcm_pkg::*;
#(
  parameter int CHECK_PERIOD  = CHECK_PERIOD_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_dummy_mode,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [31:0]           in_capture_value,
  input  wire logic [1:0]            in_new_status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [FREQ_W-1:0]          out_frequency,
  output logic [GAP_PORT_W-1:0]      out_pulse_gap,
  output logic                       out_detector_enable
);

  logic                     dummy_r;
  logic [TICK_W-1:0]        tick_r, tick_nxt;
  status_t                  status_r, status_nxt;
  logic [1:0]               wd_r, wd_nxt;
  logic [COUNTER_WIDTH-1:0] last_r, last_nxt;
  logic [COUNTER_WIDTH-1:0] prev_r, prev_nxt;
  logic [COUNTER_WIDTH-1:0] gap_r, gap_nxt;
  logic [FREQ_W-1:0]        freq_r, freq_nxt;
  logic                     en_r, en_nxt;
  logic                     need_div;
  logic                     div_busy;
  logic [FREQ_NUM_W-1:0]    quotient;
  logic [FREQ_NUM_W:0]      rounded;
  logic [2*FREQ_NUM_W+1:0]  product;

  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [FREQ_W-1:0]        out_freq_r;
  logic [COUNTER_WIDTH-1:0] out_gap_r;
  logic                     out_en_r;

  // Next state for one accepted transaction. The frequency of a check is
  // filled in later, once the divider has finished.
  always_comb begin
    tick_nxt   = tick_r;
    status_nxt = status_r;
    wd_nxt     = wd_r;
    last_nxt   = last_r;
    prev_nxt   = prev_r;
    gap_nxt    = gap_r;
    freq_nxt   = freq_r;
    en_nxt     = en_r;
    need_div   = 1'b0;
    unique case (in_opcode)
      OP_TICK: begin
        if (dummy_r) begin
          status_nxt = ST_ACTIVE;
        end else if (tick_r < TICK_W'(CHECK_PERIOD - 1)) begin
          tick_nxt = tick_r + 1'b1;
        end else begin
          tick_nxt = '0;
          if (status_r == ST_ACTIVE) begin
            wd_nxt = (wd_r < WATCHDOG_LIMIT) ? wd_r + 1'b1 : wd_r;
          end else begin
            wd_nxt = '0;
          end
          if (wd_nxt >= WATCHDOG_LIMIT) begin
            status_nxt = ST_ERROR;
            freq_nxt   = '0;
            gap_nxt    = '0;
            last_nxt   = '0;
            prev_nxt   = '0;
          end else if (last_r > prev_r) begin
            if (status_r == ST_ERROR) begin
              status_nxt = ST_ACTIVE;
            end
            gap_nxt  = last_r - prev_r;
            need_div = 1'b1;
          end
        end
      end
      OP_CAPTURE: begin
        if (status_r == ST_ACTIVE || status_r == ST_ERROR) begin
          prev_nxt = last_r;
          last_nxt = in_capture_value[COUNTER_WIDTH-1:0];
        end
        wd_nxt = '0;
      end
      OP_SET: begin
        unique case (in_new_status)
          ST_ACTIVE: begin
            status_nxt = ST_ACTIVE;
            en_nxt     = 1'b1;
          end
          ST_OFF, ST_ERROR: begin
            status_nxt = status_t'(in_new_status);
            en_nxt     = 1'b0;
            freq_nxt   = '0;
            gap_nxt    = '0;
            last_nxt   = '0;
            prev_nxt   = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  mzcm_div #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.accept && need_div),
    .divisor (gap_r),
    .busy    (div_busy),
    .quotient(quotient)
  );

  // Round to the nearest tenth and divide by ten through the reciprocal.
  assign rounded = {1'b0, quotient} + FREQ_ROUND;
  assign product = rounded * RECIP_TEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dummy_r  <= 1'b0;
      tick_r   <= TICK_START;
      status_r <= ST_OFF;
      wd_r     <= '0;
      last_r   <= '0;
      prev_r   <= '0;
      gap_r    <= '0;
      freq_r   <= '0;
      en_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dummy_r <= cfg_dummy_mode;
      end
      if (cmd.accept) begin
        tick_r   <= tick_nxt;
        status_r <= status_nxt;
        wd_r     <= wd_nxt;
        last_r   <= last_nxt;
        prev_r   <= prev_nxt;
        gap_r    <= gap_nxt;
        freq_r   <= freq_nxt;
        en_r     <= en_nxt;
      end else if (cmd.mul_load) begin
        freq_r <= product[RECIP_SHIFT +: FREQ_W];
      end
    end
  end

  // Output register: holds one finished result until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_freq_r   <= freq_r;
      out_gap_r    <= gap_r;
      out_en_r     <= en_r;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_frequency       = out_freq_r;
  assign out_pulse_gap       = GAP_PORT_W'(out_gap_r);
  assign out_detector_enable = out_en_r;

endmodule : mzcm_dp
`default_nettype wire

### sv/mzcm_ctrl.sv
`default_nettype none
// ============================================================================
// mzcm_ctrl
// Sequencer: accept, optional division and rounding, then hand off the result.
// ============================================================================
module mzcm_ctrl
  import mzcm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.mul_load = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_div ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : mzcm_ctrl
`default_nettype wire

### sv/mains_zero_cross_monitor_unit.sv
`default_nettype none
// ============================================================================
// mains_zero_cross_monitor_unit
// Zero-cross monitor: status, watchdog, pulse gap and rounded frequency.
// ============================================================================
// Sequence: an accepted transaction updates the state, then the output
//   register is loaded; a periodic check that recomputes the frequency
//   first waits for the 23 iterations of the bit-serial divider, sees it
//   done, takes one rounding step and then loads the output register.
// Transactions do not overlap: a new one waits for the last output load.
// Reset: synchronous, active low; status off, tick count 40, other state zero.
// ============================================================================
module mains_zero_cross_monitor_unit
  import mzcm_pkg::*;
#(
  parameter int CHECK_PERIOD  = CHECK_PERIOD_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration write channel: the dummy mode register.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_dummy_mode,
  // Event channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [31:0]       in_capture_value,
  input  wire logic [1:0]        in_new_status,
  // Result channel: the state after each event.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [FREQ_W-1:0]      out_frequency,
  output logic [GAP_PORT_W-1:0]  out_pulse_gap,
  output logic                   out_detector_enable
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The register write always completes in the cycle it is offered.
  assign cfg_ready = 1'b1;

  // The controller accepts a transaction only when no earlier one is still
  // in flight; a finished result may still sit in the output register, so
  // the next event is taken while the result side stalls.
  mzcm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the monitor state, applies each event in the cycle it
  // is accepted, runs the divider for a frequency update, and owns the
  // output register.
  mzcm_dp #(
    .CHECK_PERIOD (CHECK_PERIOD),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_dummy_mode     (cfg_dummy_mode),
    .in_opcode          (in_opcode),
    .in_capture_value   (in_capture_value),
    .in_new_status      (in_new_status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_frequency      (out_frequency),
    .out_pulse_gap      (out_pulse_gap),
    .out_detector_enable(out_detector_enable)
  );

  // After a transaction is accepted, the block is not ready in the cycle after.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while the previous one was still in flight");

  // The divider only runs while a transaction is being processed.
  a_div_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_ready)
    else $error("divider busy while the controller is idle");

  // A nonzero frequency always comes from a nonzero pulse gap.
  a_freq_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frequency != '0) |-> (out_pulse_gap != '0))
    else $error("frequency reported without a pulse gap");

  // A rounding step must never start while the divider is still iterating.
  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_load |-> !sts.div_busy)
    else $error("frequency loaded before the division finished");

endmodule : mains_zero_cross_monitor_unit
`default_nettype wire
